@@ rtl/sroe_pkg.sv @@
package sroe_pkg;

  // Command codes of the input transaction
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd0;
  localparam logic [2:0] CMD_SET_BIT    = 3'd1;
  localparam logic [2:0] CMD_SET_PIN    = 3'd2;
  localparam logic [2:0] CMD_PRESET_BIT = 3'd3;
  localparam logic [2:0] CMD_OR_MASK    = 3'd4;
  localparam logic [2:0] CMD_CLEAR_MASK = 3'd5;
  localparam logic [2:0] CMD_UPDATE     = 3'd6;
  localparam logic [2:0] CMD_READ_BIT   = 3'd7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_ENABLE = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] byte_index;
    logic [3:0] bit_number;
    logic [6:0] pin_number;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic is_read;
    logic serial_bit;
    logic pin_level;
    logic last;
  } out_item_t;

  // Job kind and read answer passed from the front end to the serializer
  typedef struct packed {
    logic is_read;
    logic level;
  } job_ctl_t;

endpackage

@@ rtl/sroe_front.sv @@
module sroe_front #(
  parameter int unsigned MAX_BYTES = 8,
  parameter int unsigned IDX_W     = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept_i,
  input  sroe_pkg::in_item_t       item_i,
  input  logic                     send_ok_i,
  input  logic [IDX_W-1:0]         start_i,
  output logic                     push_o,
  output sroe_pkg::job_ctl_t       ctl_o,
  output logic [IDX_W-1:0]         start_o,
  output logic [MAX_BYTES*8-1:0]   img_o
);

  logic [MAX_BYTES*8-1:0] image_r;
  logic [MAX_BYTES*8-1:0] image_nxt;
  logic [IDX_W-1:0]       slot_lut [8];
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       addr;
  logic [6:0]             pin_m1;
  logic [2:0]             pin_byte;
  logic                   pin_ok;
  logic                   pin_in;
  logic                   bit_ok;
  logic [2:0]             bit_sel;
  logic [7:0]             bit_mask;
  logic [7:0]             pin_mask;
  logic                   level;
  logic [7:0]             old_byte;
  logic [7:0]             new_byte;

  // Fold byte index onto the image depth
  for (genvar g = 0; g < 8; g++) begin : g_slot
    assign slot_lut[g] = IDX_W'(g % MAX_BYTES);
  end

  // Decode addressing and build the modified byte
  always_comb begin
    slot     = slot_lut[item_i.byte_index];
    pin_m1   = item_i.pin_number - 7'd1;
    pin_ok   = (item_i.pin_number != 7'd0) && (item_i.pin_number <= 7'd64);
    pin_byte = pin_m1[5:3];
    pin_in   = {1'b0, pin_byte} < 4'(MAX_BYTES);
    pin_mask = 8'd1 << pin_m1[2:0];
    bit_ok   = (item_i.bit_number != 4'd0) && (item_i.bit_number <= 4'd8);
    bit_sel  = 3'(item_i.bit_number - 4'd1);
    bit_mask = 8'd1 << bit_sel;
    level    = item_i.value == 8'd1;

    if (item_i.cmd == sroe_pkg::CMD_SET_PIN && pin_ok && pin_in) begin
      addr = pin_byte[IDX_W-1:0];
    end else begin
      addr = slot;
    end
    old_byte = image_r[addr*8 +: 8];

    case (item_i.cmd)
      sroe_pkg::CMD_WRITE_BYTE: begin
        new_byte = item_i.value;
      end
      sroe_pkg::CMD_SET_BIT, sroe_pkg::CMD_PRESET_BIT: begin
        if (!bit_ok) new_byte = old_byte;
        else if (level) new_byte = old_byte | bit_mask;
        else new_byte = old_byte & ~bit_mask;
      end
      sroe_pkg::CMD_SET_PIN: begin
        if (!(pin_ok && pin_in)) new_byte = old_byte;
        else if (level) new_byte = old_byte | pin_mask;
        else new_byte = old_byte & ~pin_mask;
      end
      sroe_pkg::CMD_OR_MASK: begin
        new_byte = old_byte | item_i.value;
      end
      sroe_pkg::CMD_CLEAR_MASK: begin
        new_byte = old_byte & ~item_i.value;
      end
      default: begin
        new_byte = old_byte;
      end
    endcase

    image_nxt = image_r;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (IDX_W'(i) == addr) image_nxt[i*8 +: 8] = new_byte;
    end
  end

  // Classify: reads always answer, image commands other than preset send when sending is on
  always_comb begin
    push_o        = accept_i && ((item_i.cmd == sroe_pkg::CMD_READ_BIT) ||
                    ((item_i.cmd != sroe_pkg::CMD_PRESET_BIT) && send_ok_i));
    ctl_o.is_read = item_i.cmd == sroe_pkg::CMD_READ_BIT;
    ctl_o.level   = bit_ok && old_byte[bit_sel];
    start_o       = start_i;
    img_o         = image_nxt;
  end

  // Hold the output image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r <= '0;
    end else if (accept_i) begin
      image_r <= image_nxt;
    end
  end

endmodule

@@ rtl/sroe_queue.sv @@
module sroe_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] dout_o
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign full_o  = cnt_r == 2'd2;
  assign empty_o = cnt_r == 2'd0;
  assign dout_o  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i) rd_ptr_r <= ~rd_ptr_r;
      if (push_i && !pop_i) cnt_r <= cnt_r + 2'd1;
      else if (pop_i && !push_i) cnt_r <= cnt_r - 2'd1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= din_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
`endif

endmodule

@@ rtl/sroe_back.sv @@
module sroe_back #(
  parameter int unsigned MAX_BYTES = 8,
  parameter int unsigned IDX_W     = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     msb_first_i,
  input  logic                     job_empty_i,
  input  sroe_pkg::job_ctl_t       job_ctl_i,
  input  logic [IDX_W-1:0]         job_start_i,
  input  logic [MAX_BYTES*8-1:0]   job_img_i,
  output logic                     job_pop_o,
  input  logic                     out_pop_i,
  output logic                     out_empty_o,
  output sroe_pkg::out_item_t      out_item_o
);

  typedef enum logic {ST_IDLE, ST_SEND} st_t;

  st_t                    st_r, st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sroe_pkg::out_item_t    out_item_r, out_item_nxt;
  logic [MAX_BYTES*8-1:0] img_r, img_nxt;
  logic [IDX_W-1:0]       byte_r, byte_nxt;
  logic [2:0]             k_r, k_nxt;
  logic                   adv;
  logic [7:0]             cur_byte;
  logic [2:0]             pos;
  logic                   last_bit;

  // Serialize the snapshot one bit per output slot
  always_comb begin
    adv           = !out_valid_r || out_pop_i;
    cur_byte      = img_r[byte_r*8 +: 8];
    pos           = msb_first_i ? (3'd7 - k_r) : k_r;
    last_bit      = (byte_r == '0) && (k_r == 3'd7);
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    img_nxt       = img_r;
    byte_nxt      = byte_r;
    k_nxt         = k_r;
    job_pop_o     = 1'b0;

    if (adv) out_valid_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (!job_empty_i) begin
          if (job_ctl_i.is_read) begin
            if (adv) begin
              job_pop_o               = 1'b1;
              out_valid_nxt           = 1'b1;
              out_item_nxt.is_read    = 1'b1;
              out_item_nxt.serial_bit = 1'b0;
              out_item_nxt.pin_level  = job_ctl_i.level;
              out_item_nxt.last       = 1'b1;
            end
          end else begin
            job_pop_o = 1'b1;
            img_nxt   = job_img_i;
            byte_nxt  = job_start_i;
            k_nxt     = 3'd0;
            st_nxt    = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        if (adv) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.is_read    = 1'b0;
          out_item_nxt.serial_bit = cur_byte[pos];
          out_item_nxt.pin_level  = 1'b0;
          out_item_nxt.last       = last_bit;
          k_nxt                   = k_r + 3'd1;
          if (k_r == 3'd7) byte_nxt = byte_r - IDX_W'(1);
          if (last_bit) st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_empty_o = !out_valid_r;
  assign out_item_o  = out_item_r;

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
    img_r      <= img_nxt;
    byte_r     <= byte_nxt;
    k_r        <= k_nxt;
  end

`ifndef ASSERT_OFF
  a_read_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.is_read) |-> (out_item_r.last && !out_item_r.serial_bit))
    else $error("read answer must be a single final transaction");
  a_send_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && job_pop_o && !job_ctl_i.is_read) |=>
      (st_r == ST_SEND && k_r == 3'd0))
    else $error("send job did not start serializing");
`endif

endmodule

@@ rtl/shift_register_output_expander.sv @@
// Channel   Handshake            Payload                 Transaction when
// input     in_push / in_full    in_item (in_item_t)     in_push && !in_full
// result    out_empty / out_pop  out_item (out_item_t)   out_pop && !out_empty
// config    cfg_we               cfg_index, cfg_wdata    cfg_we
//
// A send serializes byte_count*8 bits (byte_count capped at MAX_BYTES) after the job is
// loaded into the serializer; a read answer is a single result.
// The front end takes one command per cycle while the two-entry job queue has room.
// Reset (synchronous, rst_n low) clears the image to zero and restores the registers.
// A stalled result holds the serializer; commands keep landing until the queue fills.
module shift_register_output_expander #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  sroe_pkg::in_item_t                   in_item,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output sroe_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [sroe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sroe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned IMG_W = MAX_BYTES * 8;
  localparam int unsigned JOB_W = 2 + IDX_W + IMG_W;

  logic               msb_first_r;
  logic [3:0]         byte_count_r;
  logic               send_enable_r;
  logic [3:0]         n_sat;
  logic [3:0]         n_m1;
  logic               send_ok;
  logic [IDX_W-1:0]   start;
  logic               accept;

  logic               f_push;
  sroe_pkg::job_ctl_t f_ctl;
  logic [IDX_W-1:0]   f_start;
  logic [IMG_W-1:0]   f_img;

  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic [JOB_W-1:0]   q_dout;

  sroe_pkg::job_ctl_t b_ctl;
  logic [IDX_W-1:0]   b_start;
  logic [IMG_W-1:0]   b_img;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msb_first_r   <= 1'b1;
      byte_count_r  <= 4'd3;
      send_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sroe_pkg::CFG_MSB_FIRST:   msb_first_r   <= cfg_wdata[0];
        sroe_pkg::CFG_BYTE_COUNT:  byte_count_r  <= cfg_wdata;
        sroe_pkg::CFG_SEND_ENABLE: send_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturate byte count and derive the first byte sent
  always_comb begin
    n_sat   = (byte_count_r > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : byte_count_r;
    n_m1    = n_sat - 4'd1;
    start   = n_m1[IDX_W-1:0];
    send_ok = send_enable_r && (byte_count_r != 4'd0);
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  sroe_front #(
    .MAX_BYTES (MAX_BYTES),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .item_i    (in_item),
    .send_ok_i (send_ok),
    .start_i   (start),
    .push_o    (f_push),
    .ctl_o     (f_ctl),
    .start_o   (f_start),
    .img_o     (f_img)
  );

  sroe_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .din_i   ({f_ctl, f_start, f_img}),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .dout_o  (q_dout)
  );

  assign {b_ctl, b_start, b_img} = q_dout;

  sroe_back #(
    .MAX_BYTES (MAX_BYTES),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .msb_first_i (msb_first_r),
    .job_empty_i (q_empty),
    .job_ctl_i   (b_ctl),
    .job_start_i (b_start),
    .job_img_i   (b_img),
    .job_pop_o   (q_pop),
    .out_pop_i   (out_pop),
    .out_empty_o (out_empty),
    .out_item_o  (out_item)
  );

endmodule

@@ tb/shift_register_output_expander_tb.sv @@
module shift_register_output_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the end of the register list; a write there must change nothing
  localparam logic [sroe_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned CHAIN_BYTES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  sroe_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  sroe_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [sroe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sroe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  shift_register_output_expander #(
    .MAX_BYTES(CHAIN_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: image, registers and the results still owed
  logic [7:0] chain_image [CHAIN_BYTES];
  logic       shadow_msb_first = 1'b1;
  logic [3:0] shadow_byte_count = 4'd3;
  logic       shadow_send_enable = 1'b1;
  sroe_pkg::out_item_t expected_chain_q [$];
  sroe_pkg::in_item_t  pending_cmds [$];

  int mismatches = 0;
  int cmds_accepted = 0;
  int results_checked = 0;

  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic rx_blocked = 1'b0;
  logic hold_go = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(string what, sroe_pkg::out_item_t want_v,
                               sroe_pkg::out_item_t got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %b, got %b at %0t", what, want_v, got_v, $realtime);
  endtask

  // Queue the serial bits of one send, highest byte first, latch on the final bit
  task automatic send_image();
    int n;
    int pos;
    sroe_pkg::out_item_t r;
    if (!shadow_send_enable) return;
    n = (int'(shadow_byte_count) > int'(CHAIN_BYTES)) ? int'(CHAIN_BYTES)
                                                      : int'(shadow_byte_count);
    for (int b = n; b > 0; b--) begin
      for (int k = 0; k < 8; k++) begin
        pos = shadow_msb_first ? 7 - k : k;
        r.is_read = 1'b0;
        r.serial_bit = chain_image[b-1][pos];
        r.pin_level = 1'b0;
        r.last = (b == 1 && k == 7);
        expected_chain_q.push_back(r);
      end
    end
  endtask

  // Bit positions are one-based; anything outside 1..8 leaves the byte alone
  task automatic put_bit(int slot, int bitnum, logic [7:0] level);
    if (bitnum < 1 || bitnum > 8) return;
    chain_image[slot][bitnum-1] = (level == 8'd1);
  endtask

  task automatic apply_command(sroe_pkg::in_item_t c);
    int slot;
    int p;
    sroe_pkg::out_item_t r;
    slot = int'(c.byte_index);
    cmds_accepted++;
    case (c.cmd)
      sroe_pkg::CMD_WRITE_BYTE: begin
        chain_image[slot] = c.value;
        send_image();
      end
      sroe_pkg::CMD_SET_BIT: begin
        put_bit(slot, int'(c.bit_number), c.value);
        send_image();
      end
      sroe_pkg::CMD_SET_PIN: begin
        if (c.pin_number >= 7'd1 && c.pin_number <= 7'd64) begin
          p = int'(c.pin_number) - 1;
          put_bit(p / 8, p % 8 + 1, c.value);
        end
        send_image();
      end
      sroe_pkg::CMD_PRESET_BIT: put_bit(slot, int'(c.bit_number), c.value);
      sroe_pkg::CMD_OR_MASK: begin
        chain_image[slot] = chain_image[slot] | c.value;
        send_image();
      end
      sroe_pkg::CMD_CLEAR_MASK: begin
        chain_image[slot] = chain_image[slot] & ~c.value;
        send_image();
      end
      sroe_pkg::CMD_UPDATE: send_image();
      default: begin
        r.is_read = 1'b1;
        r.serial_bit = 1'b0;
        r.pin_level = (c.bit_number >= 4'd1 && c.bit_number <= 4'd8) ?
                      chain_image[slot][c.bit_number-4'd1] : 1'b0;
        r.last = 1'b1;
        expected_chain_q.push_back(r);
      end
    endcase
  endtask

  // Driver: record each accepted transaction, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && in_full)) begin
      if (in_push) apply_command(in_item);
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_push <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_item <= pending_cmds.pop_front();
        in_push <= 1'b1;
        if (tx_idle_on && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 13);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin : result_monitor
    sroe_pkg::out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_chain_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_item);
        end else begin
          want = expected_chain_q.pop_front();
          results_checked++;
          if (out_item !== want)
            flag_mismatch("result {is_read,serial_bit,pin_level,last}", want, out_item);
        end
      end
      if (rx_blocked) begin
        out_pop <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 13);
      end
    end
  end

  // Hold the result side off long enough for the block to fill and stall input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_blocked <= 1'b1;
    repeat (200) @(posedge clk);
    rx_blocked <= 1'b0;
  end

  task automatic write_reg(logic [sroe_pkg::CFG_IDX_W-1:0] idx,
                           logic [sroe_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sroe_pkg::CFG_MSB_FIRST:   shadow_msb_first = data[0];
      sroe_pkg::CFG_BYTE_COUNT:  shadow_byte_count = data;
      sroe_pkg::CFG_SEND_ENABLE: shadow_send_enable = data[0];
      default: ;
    endcase
  endtask

  function automatic sroe_pkg::in_item_t make_cmd(logic [2:0] cmd, logic [2:0] idx,
                                                  logic [3:0] bitn, logic [6:0] pin,
                                                  logic [7:0] val);
    sroe_pkg::in_item_t c;
    c.cmd = cmd;
    c.byte_index = idx;
    c.bit_number = bitn;
    c.pin_number = pin;
    c.value = val;
    return c;
  endfunction

  // Mostly in-range addresses; bit commands mostly carry a clean 0 or 1
  function automatic sroe_pkg::in_item_t random_cmd();
    sroe_pkg::in_item_t c;
    c.cmd = 3'($urandom_range(0, 7));
    c.byte_index = 3'($urandom_range(0, 7));
    c.bit_number = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
    c.pin_number = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(1, 64));
    if (c.cmd == sroe_pkg::CMD_SET_BIT || c.cmd == sroe_pkg::CMD_SET_PIN ||
        c.cmd == sroe_pkg::CMD_PRESET_BIT)
      c.value = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    else
      c.value = 8'($urandom);
    return c;
  endfunction

  // Wait until every command is in and every result out, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_push || expected_chain_q.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_random(int n);
    @(negedge clk);
    repeat (n) pending_cmds.push_back(random_cmd());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < CHAIN_BYTES; i++) chain_image[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands under the reset settings
    @(negedge clk);
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_WRITE_BYTE, 3'd0, 4'd1, 7'd1, 8'hA5));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_WRITE_BYTE, 3'd2, 4'd8, 7'd64, 8'h3C));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_WRITE_BYTE, 3'd7, 4'd15, 7'd127, 8'hFF));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_BIT, 3'd1, 4'd1, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_BIT, 3'd1, 4'd8, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_BIT, 3'd1, 4'd8, 7'd0, 8'd2));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_BIT, 3'd0, 4'd0, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_BIT, 3'd0, 4'd15, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_PIN, 3'd0, 4'd0, 7'd1, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_PIN, 3'd0, 4'd0, 7'd64, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_PIN, 3'd0, 4'd0, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_PIN, 3'd0, 4'd0, 7'd127, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_SET_PIN, 3'd0, 4'd0, 7'd17, 8'd0));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_PRESET_BIT, 3'd2, 4'd5, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_PRESET_BIT, 3'd2, 4'd9, 7'd0, 8'd1));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_OR_MASK, 3'd2, 4'd0, 7'd0, 8'h81));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_CLEAR_MASK, 3'd0, 4'd0, 7'd0, 8'hFF));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_UPDATE, 3'd7, 4'd15, 7'd127, 8'hFF));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_READ_BIT, 3'd2, 4'd5, 7'd0, 8'd0));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_READ_BIT, 3'd7, 4'd8, 7'd0, 8'd0));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_READ_BIT, 3'd0, 4'd0, 7'd0, 8'd0));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_READ_BIT, 3'd3, 4'd15, 7'd0, 8'd0));
    pending_cmds.push_back(make_cmd(sroe_pkg::CMD_WRITE_BYTE, 3'd5, 4'd0, 7'd127, 8'h00));
    wait_drained();

    // Random traffic with one long stall on the result side
    hold_go = 1'b1;
    run_random(60);

    // LSB first over the full chain; upper data bits must not matter
    write_reg(sroe_pkg::CFG_MSB_FIRST, 4'hE);
    write_reg(sroe_pkg::CFG_BYTE_COUNT, 4'd8);
    run_random(25);

    write_reg(sroe_pkg::CFG_MSB_FIRST, 4'd1);
    write_reg(sroe_pkg::CFG_BYTE_COUNT, 4'd1);
    run_random(50);

    // Zero bytes per send: only reads answer
    write_reg(sroe_pkg::CFG_BYTE_COUNT, 4'd0);
    run_random(25);

    // Count past the chain depth saturates
    write_reg(sroe_pkg::CFG_MSB_FIRST, 4'd0);
    write_reg(sroe_pkg::CFG_BYTE_COUNT, 4'd15);
    run_random(20);

    // Sending off; the unused register index must be ignored
    write_reg(CFG_UNUSED_IDX, 4'hF);
    write_reg(sroe_pkg::CFG_SEND_ENABLE, 4'd0);
    write_reg(sroe_pkg::CFG_BYTE_COUNT, 4'd2);
    run_random(40);

    // Final stretch at full rate on both sides
    write_reg(sroe_pkg::CFG_SEND_ENABLE, 4'd1);
    write_reg(sroe_pkg::CFG_MSB_FIRST, 4'd1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(70);

    repeat (30) @(negedge clk);
    $display("run: %0d commands over seven register settings, %0d results checked, %0d mismatches",
             cmds_accepted, results_checked, mismatches);
    if (mismatches == 0 && expected_chain_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sroe_pkg.sv
rtl/sroe_front.sv
rtl/sroe_queue.sv
rtl/sroe_back.sv
rtl/shift_register_output_expander.sv
tb/shift_register_output_expander_tb.sv
